>>> rtl/heater_window_control_assert.svh
// ----------------------------------------------------------------------------
// heater_window_control_assert.svh
// Assertion macros for the checker file of the heater window control.
// ----------------------------------------------------------------------------
`ifndef HEATER_WINDOW_CONTROL_ASSERT_SVH
`define HEATER_WINDOW_CONTROL_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define HWC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heater_window_control: assertion failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define HWC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heater_window_control: assertion failed");

`endif

>>> rtl/hwc_pkg.sv
// ----------------------------------------------------------------------------
// hwc_pkg
// Types and constants of the heater window control.
// ----------------------------------------------------------------------------
`default_nettype none

package hwc_pkg;

  // Request kinds
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Readings below 1 degree C count as a broken sensor
  localparam logic [13:0] LOW_TEMP_Q4 = 14'd16;
  localparam logic [8:0]  ALPHA_MAX   = 9'd256;

  typedef enum logic [1:0] {
    MODE_WARMING = 2'd0,
    MODE_READY   = 2'd1,
    MODE_FAULT   = 2'd2
  } hwc_mode_t;

  typedef enum logic [2:0] {
    REG_SETPOINT     = 3'd0,
    REG_READY_MARGIN = 3'd1,
    REG_MAX_SAFE     = 3'd2,
    REG_TURBO_GAP    = 3'd3,
    REG_WINDOW       = 3'd4,
    REG_FORCE        = 3'd5,
    REG_EMA_ALPHA    = 3'd6
  } hwc_reg_t;

  localparam logic [11:0] SETPOINT_RST     = 12'd1488;
  localparam logic [9:0]  READY_MARGIN_RST = 10'd16;
  localparam logic [13:0] MAX_SAFE_RST     = 14'd2400;
  localparam logic [11:0] TURBO_GAP_RST    = 12'd320;
  localparam logic [15:0] WINDOW_RST       = 16'd1000;
  localparam logic [15:0] FORCE_RST        = 16'd0;
  localparam logic [8:0]  EMA_ALPHA_RST    = 9'd64;

  typedef struct packed {
    logic        op;
    logic [13:0] temp_q4;
    logic        sensor_fault;
    logic [15:0] drive_ms;
    logic        extracting;
    logic        warming_override;
    logic        busy_req;
  } hwc_in_t;

  typedef struct packed {
    logic        heater_on;
    logic [1:0]  mode;
    logic [13:0] smoothed_q4;
    logic        became_ready;
  } hwc_out_t;

  typedef struct packed {
    logic [11:0] setpoint_q4;
    logic [9:0]  ready_margin_q4;
    logic [13:0] max_safe_q4;
    logic [11:0] turbo_gap_q4;
    logic [15:0] window_ms;
    logic [15:0] force_ms;
    logic [8:0]  ema_alpha_q8;
  } hwc_cfg_t;

  // Fixed-width part of the control state
  typedef struct packed {
    logic [13:0] smoothed;
    logic [13:0] last_temp;
    hwc_mode_t   mode;
    logic        was_extracting;
  } hwc_state_t;

endpackage

`default_nettype wire

>>> rtl/hwc_step.sv
// ----------------------------------------------------------------------------
// hwc_step
// Next state and result for one request: smoothing, mode and heater decision.
// ----------------------------------------------------------------------------
`default_nettype none

module hwc_step import hwc_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  hwc_in_t               req_i,
  input  hwc_cfg_t              cfg_i,
  input  hwc_state_t            st_i,
  input  logic [COUNT_BITS-1:0] window_count_i,
  input  logic [COUNT_BITS-1:0] extract_count_i,
  output hwc_state_t            st_o,
  output logic [COUNT_BITS-1:0] window_count_o,
  output logic [COUNT_BITS-1:0] extract_count_o,
  output hwc_out_t              res_o
);

  localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic                  is_tick;
  logic                  is_live_sample;
  logic                  go_fault;
  logic                  sample_ok;
  logic [COUNT_BITS-1:0] win_tick;
  logic [COUNT_BITS-1:0] ext_tick;
  logic [8:0]            alpha;
  logic [13:0]           ema_old;
  logic signed [14:0]    ema_diff;
  logic signed [24:0]    ema_prod;
  logic signed [23:0]    ema_acc;
  logic signed [12:0]    ready_level;
  logic                  temp_ge_level;
  hwc_mode_t             mode_nxt;
  logic                  ready_pulse;
  logic signed [14:0]    gap;
  logic                  heater;

  // Counters and smoothing
  always_comb begin
    is_tick        = (req_i.op == OP_TICK);
    is_live_sample = (req_i.op == OP_SAMPLE) && (st_i.mode != MODE_FAULT);
    go_fault       = is_live_sample && (req_i.sensor_fault || (req_i.temp_q4 < LOW_TEMP_Q4));
    sample_ok      = is_live_sample && !go_fault;

    win_tick = window_count_i;
    ext_tick = extract_count_i;
    if (is_tick) begin
      if (window_count_i != '1) begin
        win_tick = window_count_i + 1'b1;
      end
      if (req_i.extracting && st_i.was_extracting && (extract_count_i != '1)) begin
        ext_tick = extract_count_i + 1'b1;
      end
    end
    // Rising edge of extraction restarts the forced-on timer
    if (req_i.extracting && !st_i.was_extracting) begin
      ext_tick = '0;
    end

    alpha    = (cfg_i.ema_alpha_q8 > ALPHA_MAX) ? ALPHA_MAX : cfg_i.ema_alpha_q8;
    // First good sample seeds the average
    ema_old  = (st_i.smoothed == '0) ? req_i.temp_q4 : st_i.smoothed;
    ema_diff = $signed({1'b0, req_i.temp_q4}) - $signed({1'b0, ema_old});
    ema_prod = $signed({1'b0, alpha}) * ema_diff;
    ema_acc  = $signed({2'b00, ema_old, 8'h00}) + $signed(ema_prod[23:0]) + 24'sd128;

    ready_level   = $signed({1'b0, cfg_i.setpoint_q4}) - $signed({3'b000, cfg_i.ready_margin_q4});
    temp_ge_level = $signed({1'b0, req_i.temp_q4}) >= ready_level;
  end

  // Mode transitions
  always_comb begin
    mode_nxt    = st_i.mode;
    ready_pulse = 1'b0;
    if (go_fault) begin
      mode_nxt = MODE_FAULT;
    end else if (sample_ok && !req_i.busy_req) begin
      case (st_i.mode)
        MODE_WARMING: begin
          if (temp_ge_level) begin
            mode_nxt    = MODE_READY;
            ready_pulse = 1'b1;
          end
        end
        MODE_READY: begin
          if (!temp_ge_level && !req_i.warming_override) begin
            mode_nxt = MODE_WARMING;
          end
        end
        default: begin
          mode_nxt = st_i.mode;
        end
      endcase
    end
  end

  // Heater decision and outputs
  always_comb begin
    st_o.mode           = mode_nxt;
    st_o.was_extracting = req_i.extracting;
    st_o.smoothed       = sample_ok ? ema_acc[21:8] : st_i.smoothed;
    st_o.last_temp      = sample_ok ? req_i.temp_q4 : st_i.last_temp;
    extract_count_o     = ext_tick;
    window_count_o      = win_tick;
    heater              = 1'b0;
    gap = $signed({3'b000, cfg_i.setpoint_q4}) - $signed({1'b0, st_o.last_temp});

    if ((mode_nxt != MODE_FAULT) && (st_o.smoothed != '0)) begin
      if (st_o.last_temp >= cfg_i.max_safe_q4) begin
        heater = 1'b0;
      end else if (req_i.extracting && (CMP_W'(ext_tick) <= CMP_W'(cfg_i.force_ms))) begin
        heater = 1'b1;
      end else begin
        // Restart the window once past its end
        if (CMP_W'(win_tick) > CMP_W'(cfg_i.window_ms)) begin
          window_count_o = '0;
        end
        if (gap > $signed({3'b000, cfg_i.turbo_gap_q4})) begin
          heater = 1'b1;
        end else begin
          heater = CMP_W'(req_i.drive_ms) > CMP_W'(window_count_o);
        end
      end
    end

    res_o.heater_on    = heater;
    res_o.mode         = mode_nxt;
    res_o.smoothed_q4  = st_o.smoothed;
    res_o.became_ready = ready_pulse;
  end

endmodule

`default_nettype wire

>>> rtl/heater_window_control.sv
// ----------------------------------------------------------------------------
// heater_window_control
// Boiler heater drive with sticky sensor fault, smoothed temperature,
// warming/ready mode and time-proportioning window output.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   in_     | in        | in_valid / in_ready  | in_data  (hwc_in_t)
//   out_    | out       | out_valid / out_ready| out_data (hwc_out_t)
//   cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each request passes through the input register and then the result
// register, one request per cycle sustained while results are taken.
// The step logic between the two registers sets that rate.
// A stalled result holds the result register; the input register refills
// as soon as its request moves on, so ready only falls when both are full.
// Synchronous active-low reset clears state, counters and configuration
// to their defaults. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module heater_window_control import hwc_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hwc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output hwc_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Input stage
  hwc_in_t in_r;
  logic    in_valid_r;

  // Result stage
  hwc_out_t out_r;
  logic     out_valid_r;

  // Control state
  hwc_state_t            st_r;
  logic [COUNT_BITS-1:0] window_count_r;
  logic [COUNT_BITS-1:0] extract_count_r;

  // Configuration
  hwc_cfg_t cfg_r;

  // Step results
  hwc_state_t            st_nxt;
  logic [COUNT_BITS-1:0] window_count_nxt;
  logic [COUNT_BITS-1:0] extract_count_nxt;
  hwc_out_t              out_nxt;

  logic advance;

  // Move a request into the result register when it is free or draining
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  hwc_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .req_i           (in_r),
    .cfg_i           (cfg_r),
    .st_i            (st_r),
    .window_count_i  (window_count_r),
    .extract_count_i (extract_count_r),
    .st_o            (st_nxt),
    .window_count_o  (window_count_nxt),
    .extract_count_o (extract_count_nxt),
    .res_o           (out_nxt)
  );

  // Handshake valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: capture on accept / advance
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  // Commit state as each request leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.smoothed       <= '0;
      st_r.last_temp      <= '0;
      st_r.mode           <= MODE_WARMING;
      st_r.was_extracting <= 1'b0;
      window_count_r      <= '0;
      extract_count_r     <= '0;
    end else if (advance) begin
      st_r            <= st_nxt;
      window_count_r  <= window_count_nxt;
      extract_count_r <= extract_count_nxt;
    end
  end

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint_q4     <= SETPOINT_RST;
      cfg_r.ready_margin_q4 <= READY_MARGIN_RST;
      cfg_r.max_safe_q4     <= MAX_SAFE_RST;
      cfg_r.turbo_gap_q4    <= TURBO_GAP_RST;
      cfg_r.window_ms       <= WINDOW_RST;
      cfg_r.force_ms        <= FORCE_RST;
      cfg_r.ema_alpha_q8    <= EMA_ALPHA_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SETPOINT:     cfg_r.setpoint_q4     <= cfg_data[11:0];
        REG_READY_MARGIN: cfg_r.ready_margin_q4 <= cfg_data[9:0];
        REG_MAX_SAFE:     cfg_r.max_safe_q4     <= cfg_data[13:0];
        REG_TURBO_GAP:    cfg_r.turbo_gap_q4    <= cfg_data[11:0];
        REG_WINDOW:       cfg_r.window_ms       <= cfg_data;
        REG_FORCE:        cfg_r.force_ms        <= cfg_data;
        REG_EMA_ALPHA:    cfg_r.ema_alpha_q8    <= cfg_data[8:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/hwc_checker.sv
// ----------------------------------------------------------------------------
// hwc_checker
// Port-level checks of the heater window control, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "heater_window_control_assert.svh"

module hwc_checker import hwc_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire hwc_out_t out_data
);

  logic fault_seen_r;

  // Remember that a fault result has been delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_seen_r <= 1'b0;
    end else if (out_valid && out_ready && (out_data.mode == MODE_FAULT)) begin
      fault_seen_r <= 1'b1;
    end
  end

  `HWC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `HWC_ASSERT_NOW(a_fault_sticky, out_valid && fault_seen_r, out_data.mode == MODE_FAULT)
  `HWC_ASSERT_NOW(a_fault_off, out_valid && (out_data.mode == MODE_FAULT), !out_data.heater_on)
  `HWC_ASSERT_NOW(a_pulse_ready, out_valid && out_data.became_ready, out_data.mode == MODE_READY)
  `HWC_ASSERT_NOW(a_heat_seeded, out_valid && out_data.heater_on, out_data.smoothed_q4 != '0)

endmodule

bind heater_window_control hwc_checker u_hwc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

>>> verif/hwc_result_checker.sv
// ----------------------------------------------------------------------------
// hwc_result_checker
// Watches the request, result and register channels of the heater window
// control, predicts every result from its own copy of the control state and
// compares the results in order, field by field.
// ----------------------------------------------------------------------------
module hwc_result_checker import hwc_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  hwc_in_t     in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  hwc_out_t    out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_CAP = 40;

  hwc_cfg_t               regs;
  logic [13:0]            avg_temp;
  logic [13:0]            good_temp;
  hwc_mode_t              heat_mode;
  logic [COUNT_BITS-1:0]  window_count;
  logic [COUNT_BITS-1:0]  extract_count;
  logic                   was_extracting;
  hwc_out_t               heater_results_q[$];
  int                     reports;

  // Advance the control state by one request and return the result it causes.
  function automatic hwc_out_t step_heater(hwc_in_t req);
    hwc_out_t    res;
    int unsigned weight;
    int unsigned acc;
    int          level;
    int          shortfall;
    res = '0;
    if (req.op == OP_TICK) begin
      if (window_count != '1) window_count++;
      if (req.extracting && was_extracting && extract_count != '1) extract_count++;
    end
    if (req.extracting && !was_extracting) extract_count = '0;
    was_extracting = req.extracting;

    if (req.op == OP_SAMPLE && heat_mode != MODE_FAULT) begin
      if (req.sensor_fault || req.temp_q4 < LOW_TEMP_Q4) begin
        heat_mode = MODE_FAULT;
      end else begin
        weight = (regs.ema_alpha_q8 > ALPHA_MAX) ? ALPHA_MAX : regs.ema_alpha_q8;
        level = int'(regs.setpoint_q4) - int'(regs.ready_margin_q4);
        good_temp = req.temp_q4;
        // first good reading seeds the average
        if (avg_temp == '0) avg_temp = req.temp_q4;
        acc = weight * req.temp_q4 + (ALPHA_MAX - weight) * avg_temp + 128;
        avg_temp = 14'(acc >> 8);
        if (!req.busy_req) begin
          if (heat_mode == MODE_WARMING && int'(req.temp_q4) >= level) begin
            heat_mode = MODE_READY;
            res.became_ready = 1'b1;
          end else if (heat_mode == MODE_READY && int'(req.temp_q4) < level &&
                       !req.warming_override) begin
            heat_mode = MODE_WARMING;
          end
        end
      end
    end

    if (heat_mode != MODE_FAULT && avg_temp != '0) begin
      if (good_temp >= regs.max_safe_q4) begin
        res.heater_on = 1'b0;
      end else if (req.extracting && extract_count <= regs.force_ms) begin
        res.heater_on = 1'b1;
      end else begin
        shortfall = int'(regs.setpoint_q4) - int'(good_temp);
        if (window_count > regs.window_ms) window_count = '0;
        res.heater_on = (shortfall > int'(regs.turbo_gap_q4)) ||
                        (req.drive_ms > window_count);
      end
    end
    res.mode        = heat_mode;
    res.smoothed_q4 = avg_temp;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      if (reports < REPORT_CAP)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      reports++;
    end
  endtask

  always @(posedge clk) begin : monitor
    hwc_out_t want;
    if (!rst_n) begin
      regs = '{SETPOINT_RST, READY_MARGIN_RST, MAX_SAFE_RST, TURBO_GAP_RST,
               WINDOW_RST, FORCE_RST, EMA_ALPHA_RST};
      avg_temp        = '0;
      good_temp       = '0;
      heat_mode       = MODE_WARMING;
      window_count    = '0;
      extract_count   = '0;
      was_extracting  = 1'b0;
      heater_results_q.delete();
      fail_count      = 0;
      pending_results = 0;
      reports         = 0;
    end else begin
      // compare before pushing so a result never matches its own request
      if (out_valid && out_ready) begin
        if (heater_results_q.size() == 0) begin
          fail_count++;
          if (reports < REPORT_CAP)
            $display("%0t ns: unexpected result, expected none, actual %h", $time, out_data);
          reports++;
        end else begin
          want = heater_results_q.pop_front();
          check_field("heater_on", want.heater_on, out_data.heater_on);
          check_field("mode", want.mode, out_data.mode);
          check_field("smoothed_q4", want.smoothed_q4, out_data.smoothed_q4);
          check_field("became_ready", want.became_ready, out_data.became_ready);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (hwc_reg_t'(cfg_index))
          REG_SETPOINT:     regs.setpoint_q4     = cfg_data[11:0];
          REG_READY_MARGIN: regs.ready_margin_q4 = cfg_data[9:0];
          REG_MAX_SAFE:     regs.max_safe_q4     = cfg_data[13:0];
          REG_TURBO_GAP:    regs.turbo_gap_q4    = cfg_data[11:0];
          REG_WINDOW:       regs.window_ms       = cfg_data;
          REG_FORCE:        regs.force_ms        = cfg_data;
          REG_EMA_ALPHA:    regs.ema_alpha_q8    = cfg_data[8:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) heater_results_q.push_back(step_heater(in_data));
      pending_results = heater_results_q.size();
    end
  end

endmodule

>>> verif/tb_heater_window_control.sv
// ----------------------------------------------------------------------------
// tb_heater_window_control
// Drives the heater window control with a directed opening, six register
// settings of random tick and sample traffic, and a closing fault latch,
// with random idling on both sides; the checker beside the block judges.
// ----------------------------------------------------------------------------
module tb_heater_window_control;
  timeunit 1ns;
  timeprecision 1ps;
  import hwc_pkg::*;

  localparam int STALL_LIMIT  = 1000;  // cycles without any handshake
  localparam int HOLD_AT      = 400;   // result count that starts the hold-off
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_ITEMS  = 240;
  localparam int STEADY_ITEMS = 150;
  localparam int PHASES       = 6;
  localparam int MAX_GAP      = 20;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  hwc_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  hwc_out_t    out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  int          fail_count;
  int          pending_results;
  int          out_count = 0;
  int          stall_cycles = 0;
  bit          steady = 1'b0;  // set: neither side idles

  heater_window_control #(.COUNT_BITS(16)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hwc_result_checker #(.COUNT_BITS(16)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always #5 clk = ~clk;

  // Count results for the receiver's hold-off trigger.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) out_count <= out_count + 1;
  end

  // Watchdog: end the run when no channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: stall at random, hold off once for a long stretch so that the
  // block fills up and drops in_ready while the sender keeps offering.
  initial begin : receiver
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && out_count >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 36);
      end
    end
  end

  function automatic hwc_in_t make_req(logic op, int temp, logic fault, int drive,
                                       logic extr, logic ovr, logic busy);
    hwc_in_t r;
    r.op               = op;
    r.temp_q4          = 14'(temp);
    r.sensor_fault     = fault;
    r.drive_ms         = 16'(drive);
    r.extracting       = extr;
    r.warming_override = ovr;
    r.busy_req         = busy;
    return r;
  endfunction

  // Build a random request. Most are well formed: ticks with occasional good
  // samples clustered around the setpoint, drive spread across the window.
  // The rest is noise on every field, but never a faulting reading, so the
  // sticky fault stays off until the closing part.
  function automatic hwc_in_t next_heater_request(hwc_cfg_t s, logic extr);
    hwc_in_t r;
    int      t;
    if ($urandom_range(99) < 15) begin
      r = hwc_in_t'({$urandom, $urandom});
      r.temp_q4      = 14'($urandom_range(16383, 16));
      r.sensor_fault = 1'b0;
    end else begin
      r.op = ($urandom_range(99) < 30) ? OP_SAMPLE : OP_TICK;
      t = int'(s.setpoint_q4) + int'($urandom_range(1200)) - 600;
      if ($urandom_range(9) == 0) t = $urandom_range(16383, 16);
      if (t < 16) t = 16;
      if (t > 16383) t = 16383;
      r.temp_q4          = 14'(t);
      r.sensor_fault     = 1'b0;
      r.drive_ms         = ($urandom_range(99) < 30) ? 16'($urandom) :
                           16'($urandom_range(int'(s.window_ms) + 2));
      r.extracting       = extr;
      r.warming_override = ($urandom_range(4) == 0);
      r.busy_req         = ($urandom_range(6) == 0);
    end
    return r;
  endfunction

  // Offer one request from a falling edge, hold it until accepted, then idle
  // at random. Valid stays high into the next request when there is no gap.
  task automatic send_request(input hwc_in_t req);
    int gap;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    gap = 0;
    if (!steady)
      while (gap < MAX_GAP && $urandom_range(99) < 36) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Write every register of a setting, back to back, one index per request.
  task automatic program_settings(input hwc_cfg_t s);
    hwc_reg_t    r;
    logic [15:0] word;
    for (int i = int'(REG_SETPOINT); i <= int'(REG_EMA_ALPHA); i++) begin
      r = hwc_reg_t'(i);
      case (r)
        REG_SETPOINT:     word = 16'(s.setpoint_q4);
        REG_READY_MARGIN: word = 16'(s.ready_margin_q4);
        REG_MAX_SAFE:     word = 16'(s.max_safe_q4);
        REG_TURBO_GAP:    word = 16'(s.turbo_gap_q4);
        REG_WINDOW:       word = s.window_ms;
        REG_FORCE:        word = s.force_ms;
        REG_EMA_ALPHA:    word = 16'(s.ema_alpha_q8);
        default:          word = '0;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= r;
      cfg_data  <= word;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and let the block drain; every request yields a result, so an
  // empty expectation store plus the pipeline depth means idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    hwc_cfg_t settings [PHASES];
    hwc_cfg_t cur;
    logic     extr;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    extr      = 1'b0;
    cur = '{SETPOINT_RST, READY_MARGIN_RST, MAX_SAFE_RST, TURBO_GAP_RST,
            WINDOW_RST, FORCE_RST, EMA_ALPHA_RST};

    // Small window with full-weight smoothing.
    settings[0] = '{12'd1488, 10'd16, 14'd2400, 12'd320, 16'd25, 16'd6, 9'd256};
    // Top of every range; the weight above 256 must saturate.
    settings[1] = '{12'd4095, 10'd1023, 14'd16383, 12'd4095, 16'hFFFF, 16'hFFFF, 9'd511};
    // Bottom of the ranges: ready level below zero, window restarting on
    // every use, no forced-on time, slowest smoothing.
    settings[2] = '{12'd0, 10'd1023, 14'd16383, 12'd0, 16'd0, 16'd0, 9'd1};
    for (int p = 3; p < 5; p++) begin
      settings[p].setpoint_q4     = 12'($urandom_range(4095));
      settings[p].ready_margin_q4 = 10'($urandom_range(1023));
      settings[p].max_safe_q4     = 14'($urandom_range(16383, 1200));
      settings[p].turbo_gap_q4    = 12'($urandom_range(600));
      settings[p].window_ms       = 16'($urandom_range(60, 1));
      settings[p].force_ms        = 16'($urandom_range(40));
      settings[p].ema_alpha_q8    = 9'($urandom_range(256, 1));
    end
    // Heater always held off by the safety limit.
    settings[4].max_safe_q4 = 14'd0;
    // Back to the reset values.
    settings[5] = cur;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening on the reset settings (level 1472, turbo below 1168).
    // Ticks before any sample keep the heater off; a fault flag on a tick
    // means nothing.
    send_request(make_req(OP_TICK, 16383, 1'b1, 65535, 1'b0, 1'b1, 1'b1));
    send_request(make_req(OP_TICK, 0, 1'b0, 0, 1'b0, 1'b0, 1'b0));
    // First sample seeds the average; far under setpoint runs turbo.
    send_request(make_req(OP_SAMPLE, 1000, 1'b0, 0, 1'b0, 1'b0, 1'b0));
    // Busy blocks the move to ready, then it happens with a pulse.
    send_request(make_req(OP_SAMPLE, 1480, 1'b0, 0, 1'b0, 1'b0, 1'b1));
    send_request(make_req(OP_SAMPLE, 1480, 1'b0, 0, 1'b0, 1'b0, 1'b0));
    send_request(make_req(OP_TICK, 0, 1'b0, 65535, 1'b0, 1'b0, 1'b0));
    // Override and busy hold ready; a plain low sample returns to warming.
    send_request(make_req(OP_SAMPLE, 1400, 1'b0, 0, 1'b0, 1'b1, 1'b0));
    send_request(make_req(OP_SAMPLE, 1400, 1'b0, 0, 1'b0, 1'b0, 1'b1));
    send_request(make_req(OP_SAMPLE, 1400, 1'b0, 0, 1'b0, 1'b0, 1'b0));
    // At and above the safety limit.
    send_request(make_req(OP_SAMPLE, 2400, 1'b0, 65535, 1'b0, 1'b0, 1'b0));
    send_request(make_req(OP_SAMPLE, 16383, 1'b0, 65535, 1'b0, 1'b0, 1'b0));
    // Extraction start forces the heater on, then the window takes over.
    send_request(make_req(OP_SAMPLE, 1300, 1'b0, 0, 1'b1, 1'b0, 1'b0));
    send_request(make_req(OP_TICK, 0, 1'b0, 500, 1'b1, 1'b0, 1'b0));
    send_request(make_req(OP_TICK, 0, 1'b0, 0, 1'b1, 1'b0, 1'b0));
    send_request(make_req(OP_TICK, 0, 1'b0, 0, 1'b0, 1'b0, 1'b0));
    // Lowest good reading.
    send_request(make_req(OP_SAMPLE, 16, 1'b0, 0, 1'b0, 1'b0, 1'b0));
    repeat (3) send_request(make_req(OP_TICK, 0, 1'b0, 3, 1'b0, 1'b0, 1'b0));
    settle();

    // Random traffic, one register setting per phase; the first part of one
    // phase runs with no idling on either side.
    for (int p = 0; p < PHASES; p++) begin
      program_settings(settings[p]);
      cur = settings[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        steady = (p == 3) && (n < STEADY_ITEMS);
        if ($urandom_range(99) < 3) extr = !extr;
        send_request(next_heater_request(cur, extr));
      end
      steady = 1'b0;
      settle();
    end

    // Latch the sticky fault last, by either cause, then show it holds.
    if ($urandom_range(1) == 0) begin
      send_request(make_req(OP_SAMPLE, 15, 1'b0, 65535, 1'b0, 1'b0, 1'b0));
      send_request(make_req(OP_SAMPLE, 3000, 1'b1, 65535, 1'b1, 1'b0, 1'b0));
    end else begin
      send_request(make_req(OP_SAMPLE, 3000, 1'b1, 65535, 1'b0, 1'b0, 1'b0));
      send_request(make_req(OP_SAMPLE, 15, 1'b0, 65535, 1'b1, 1'b0, 1'b0));
    end
    send_request(make_req(OP_TICK, 0, 1'b0, 65535, 1'b1, 1'b0, 1'b0));
    send_request(make_req(OP_SAMPLE, 1480, 1'b0, 65535, 1'b0, 1'b0, 1'b0));
    send_request(make_req(OP_SAMPLE, 0, 1'b0, 0, 1'b0, 1'b0, 1'b0));
    settle();

    if (fail_count == 0 && pending_results == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
